// ===== hdl/ast_pkg.sv =====
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types, constants and lookup tables of the swing and tilt gesture block
// ----------------------------------------------------------------------------
package ast_pkg;

  localparam int GRAV_K        = 3277;
  localparam int SMOOTH_K      = 3604;
  localparam int ENV_QUARTER_G = 1024;
  localparam int CUT_BASE      = 7500;
  localparam int K_BRIGHT      = 10650;
  localparam int K_DARK        = 39322;
  localparam int HALF_TURN_DEG = 11796480;

  localparam int SQRT_STEPS   = 18;
  localparam int CORDIC_STEPS = 16;
  localparam int DIV_STEPS    = 27;

  localparam logic [15:0] SWING_ON_RST  = 16'd2253;
  localparam logic [15:0] SWING_OFF_RST = 16'd1229;
  localparam logic [15:0] COOLDOWN_RST  = 16'd90;
  localparam logic [6:0]  SIDE_DEAD_RST = 7'd6;
  localparam logic [7:0]  SIDE_FULL_RST = 8'd32;
  localparam logic [6:0]  DEPTH_DEAD_RST = 7'd10;
  localparam logic [7:0]  DEPTH_FULL_RST = 8'd45;

  typedef enum logic [2:0] {
    REG_SWING_ON   = 3'd0,
    REG_SWING_OFF  = 3'd1,
    REG_COOLDOWN   = 3'd2,
    REG_SIDE_DEAD  = 3'd3,
    REG_SIDE_FULL  = 3'd4,
    REG_DEPTH_DEAD = 3'd5,
    REG_DEPTH_FULL = 3'd6
  } reg_e;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_GMUL, OP_GUPD, OP_RES, OP_SQM, OP_SQA, OP_SQI, OP_SQS,
    OP_ENV, OP_CINI, OP_CSTP, OP_TINI, OP_DSTP, OP_TFIN, OP_SMUL, OP_SUPD,
    OP_KMUL, OP_KIDX, OP_KMUL2, OP_KMM, OP_KMUL3, OP_KFIN, OP_COMMIT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] sel;
    logic [4:0] it;
  } cmd_t;

  typedef struct packed {
    logic tilt_en;
    logic out_free;
  } sts_t;

  function automatic logic signed [26:0] atan_deg(input logic [3:0] i);
    logic signed [26:0] v;
    case (i)
      4'd0:  v = 27'sd2949120;
      4'd1:  v = 27'sd1740967;
      4'd2:  v = 27'sd919879;
      4'd3:  v = 27'sd466945;
      4'd4:  v = 27'sd234379;
      4'd5:  v = 27'sd117266;
      4'd6:  v = 27'sd58666;
      4'd7:  v = 27'sd29335;
      4'd8:  v = 27'sd14668;
      4'd9:  v = 27'sd7334;
      4'd10: v = 27'sd3667;
      4'd11: v = 27'sd1833;
      4'd12: v = 27'sd917;
      4'd13: v = 27'sd458;
      4'd14: v = 27'sd229;
      4'd15: v = 27'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [17:0] exp2_val(input logic [4:0] j);
    logic [17:0] v;
    case (j)
      5'd0:  v = 18'd65536;
      5'd1:  v = 18'd68438;
      5'd2:  v = 18'd71468;
      5'd3:  v = 18'd74632;
      5'd4:  v = 18'd77936;
      5'd5:  v = 18'd81386;
      5'd6:  v = 18'd84990;
      5'd7:  v = 18'd88752;
      5'd8:  v = 18'd92682;
      5'd9:  v = 18'd96785;
      5'd10: v = 18'd101070;
      5'd11: v = 18'd105545;
      5'd12: v = 18'd110218;
      5'd13: v = 18'd115098;
      5'd14: v = 18'd120194;
      5'd15: v = 18'd125515;
      5'd16: v = 18'd131072;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/ast_in_if.sv =====
// ----------------------------------------------------------------------------
// ast_in_if
// Sample channel: accelerometer axes, time and sleep flag
// ----------------------------------------------------------------------------
interface ast_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic [31:0]        time_ms;
  logic               sleeping;

  modport source(output valid, accel_x, accel_y, accel_z, time_ms, sleeping, input ready);
  modport sink(input valid, accel_x, accel_y, accel_z, time_ms, sleeping, output ready);
endinterface

// ===== hdl/ast_out_if.sv =====
// ----------------------------------------------------------------------------
// ast_out_if
// Result channel: swing event and tilt controls
// ----------------------------------------------------------------------------
interface ast_out_if;
  logic               valid;
  logic               ready;
  logic               swing_fire;
  logic [15:0]        swing_energy;
  logic signed [15:0] swing_direction;
  logic               tilts_updated;
  logic signed [15:0] side_tilt;
  logic signed [15:0] depth_tilt;
  logic [13:0]        cutoff_hz;
  logic [14:0]        space_level;

  modport source(output valid, swing_fire, swing_energy, swing_direction, tilts_updated,
                 side_tilt, depth_tilt, cutoff_hz, space_level, input ready);
  modport sink(input valid, swing_fire, swing_energy, swing_direction, tilts_updated,
               side_tilt, depth_tilt, cutoff_hz, space_level, output ready);
endinterface

// ===== hdl/ast_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ast_cfg_if
// Configuration write channel
// ----------------------------------------------------------------------------
interface ast_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/ast_ctrl.sv =====
// ----------------------------------------------------------------------------
// ast_ctrl
// Sequencer that steps the datapath through one sample
// ----------------------------------------------------------------------------
module ast_ctrl import ast_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [22:0] {
    S_IDLE  = 23'(1) << 0,
    S_GMUL  = 23'(1) << 1,
    S_GUPD  = 23'(1) << 2,
    S_RES   = 23'(1) << 3,
    S_SQM   = 23'(1) << 4,
    S_SQA   = 23'(1) << 5,
    S_SQI   = 23'(1) << 6,
    S_SQS   = 23'(1) << 7,
    S_ENV   = 23'(1) << 8,
    S_CINI  = 23'(1) << 9,
    S_CSTP  = 23'(1) << 10,
    S_TINI  = 23'(1) << 11,
    S_DSTP  = 23'(1) << 12,
    S_TFIN  = 23'(1) << 13,
    S_SMUL  = 23'(1) << 14,
    S_SUPD  = 23'(1) << 15,
    S_KMUL  = 23'(1) << 16,
    S_KIDX  = 23'(1) << 17,
    S_KMUL2 = 23'(1) << 18,
    S_KMM   = 23'(1) << 19,
    S_KMUL3 = 23'(1) << 20,
    S_KFIN  = 23'(1) << 21,
    S_DONE  = 23'(1) << 22
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] sel_q, sel_d;
  logic [4:0] it_q, it_d;
  op_e        op;

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    it_d    = it_q;
    op      = OP_NOP;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op      = OP_LOAD;
          sel_d   = 2'd0;
          state_d = S_GMUL;
        end
      end
      S_GMUL: begin op = OP_GMUL; state_d = S_GUPD; end
      S_GUPD: begin op = OP_GUPD; state_d = S_RES; end
      S_RES:  begin op = OP_RES;  state_d = S_SQM; end
      S_SQM:  begin op = OP_SQM;  state_d = S_SQA; end
      S_SQA: begin
        op = OP_SQA;
        if (sel_q == 2'd2) begin
          sel_d   = 2'd0;
          state_d = S_SQI;
        end else begin
          sel_d   = sel_q + 2'd1;
          state_d = S_GMUL;
        end
      end
      S_SQI: begin op = OP_SQI; it_d = '0; state_d = S_SQS; end
      S_SQS: begin
        op = OP_SQS;
        if (it_q == 5'(SQRT_STEPS - 1)) state_d = S_ENV;
        else it_d = it_q + 5'd1;
      end
      S_ENV: begin op = OP_ENV; state_d = S_CINI; end
      S_CINI: begin
        op   = OP_CINI;
        it_d = '0;
        state_d = sts_i.tilt_en ? S_CSTP : S_KMUL;
      end
      S_CSTP: begin
        op = OP_CSTP;
        if (it_q == 5'(CORDIC_STEPS - 1)) state_d = S_TINI;
        else it_d = it_q + 5'd1;
      end
      S_TINI: begin op = OP_TINI; it_d = '0; state_d = S_DSTP; end
      S_DSTP: begin
        op = OP_DSTP;
        if (it_q == 5'(DIV_STEPS - 1)) state_d = S_TFIN;
        else it_d = it_q + 5'd1;
      end
      S_TFIN: begin op = OP_TFIN; state_d = S_SMUL; end
      S_SMUL: begin op = OP_SMUL; state_d = S_SUPD; end
      S_SUPD: begin
        op = OP_SUPD;
        if (sel_q == 2'd1) begin
          sel_d   = 2'd0;
          state_d = S_KMUL;
        end else begin
          sel_d   = 2'd1;
          state_d = S_CINI;
        end
      end
      S_KMUL:  begin op = OP_KMUL;  state_d = S_KIDX; end
      S_KIDX:  begin op = OP_KIDX;  state_d = S_KMUL2; end
      S_KMUL2: begin op = OP_KMUL2; state_d = S_KMM; end
      S_KMM:   begin op = OP_KMM;   state_d = S_KMUL3; end
      S_KMUL3: begin op = OP_KMUL3; state_d = S_KFIN; end
      S_KFIN:  begin op = OP_KFIN;  state_d = S_DONE; end
      S_DONE: begin
        if (sts_i.out_free) begin
          op      = OP_COMMIT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= '0;
      it_q    <= '0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      it_q    <= it_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o.op   = op;
  assign cmd_o.sel  = sel_q;
  assign cmd_o.it   = it_q;

endmodule

// ===== hdl/ast_dp.sv =====
// ----------------------------------------------------------------------------
// ast_dp
// Datapath: gravity filters, energy, swing logic, CORDIC, divider, cutoff curve
// ----------------------------------------------------------------------------
module ast_dp import ast_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic [31:0]        time_ms_i,
  input  logic               sleeping_i,
  input  logic               cfg_valid_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               swing_fire_o,
  output logic [15:0]        swing_energy_o,
  output logic signed [15:0] swing_direction_o,
  output logic               tilts_updated_o,
  output logic signed [15:0] side_tilt_o,
  output logic signed [15:0] depth_tilt_o,
  output logic [13:0]        cutoff_hz_o,
  output logic [14:0]        space_level_o
);

  // config
  logic [15:0] on_q, off_q, cool_q;
  logic [6:0]  sdead_q, ddead_q;
  logic [7:0]  sfull_q, dfull_q;

  // state
  logic signed [23:0] grav_q [3];
  logic [15:0]        env_q;
  logic               armed_q;
  logic [31:0]        last_q;
  logic signed [15:0] sm_q [2];
  logic               out_valid_q;
  logic               tilt_en_q;

  // work registers
  logic signed [15:0] acc_q [3];
  logic [31:0]        time_q;
  logic               sleep_q;
  logic signed [17:0] res_q [3];
  logic signed [44:0] prod_q;
  logic [34:0]        sum_q;
  logic [34:0]        sq_n_q, sq_bit_q;
  logic [35:0]        sq_r_q;
  logic [15:0]        energy_q;
  logic signed [15:0] dir_q;
  logic               fire_q;
  logic signed [26:0] cx_q, cy_q, cz_q;
  logic               zero_q, full_q;
  logic [9:0]         d4_q, rem_q;
  logic [26:0]        num_q;
  logic signed [15:0] tgt_q;
  logic signed [19:0] p_q;
  logic [17:0]        m_q;
  logic [13:0]        cut_q;
  logic [14:0]        space_q;

  // output registers
  logic               o_fire_q, o_upd_q;
  logic [15:0]        o_energy_q;
  logic signed [15:0] o_dir_q, o_side_q, o_depth_q;
  logic [13:0]        o_cut_q;
  logic [14:0]        o_space_q;

  logic signed [15:0] a_sel;
  logic signed [23:0] g_sel;
  logic signed [17:0] r_sel;
  logic signed [15:0] s_sel;
  logic signed [25:0] gdiff, mul_a;
  logic signed [18:0] mul_b;
  logic signed [28:0] gstep;
  logic signed [29:0] gsum;
  logic signed [23:0] gnew;
  logic signed [16:0] ground;
  logic [35:0]        sq_t;
  logic [15:0]        e;
  logic signed [17:0] ediff, env_sum;
  logic [15:0]        env_new;
  logic [17:0]        arx, ary;
  logic signed [17:0] dsel;
  logic signed [15:0] dir_new;
  logic signed [23:0] g_ang;
  logic signed [26:0] x0, y0, xs, ys;
  logic [3:0]         ci;
  logic [26:0]        mag;
  logic [22:0]        dead;
  logic [6:0]         dead_deg;
  logic [7:0]         full_deg;
  logic [8:0]         fdiff;
  logic [10:0]        rem_sh;
  logic [14:0]        tmag;
  logic signed [16:0] sdiff, sstep;
  logic signed [17:0] ssum;
  logic signed [15:0] snew;
  logic [4:0]         ej;
  logic [17:0]        ex_lo, ex_hi, ex_d;
  logic signed [5:0]  n6, nc;
  logic [5:0]         sh;
  logic [37:0]        vround;
  logic [37:0]        vout;
  logic [13:0]        cut_new;
  logic signed [16:0] half;

  assign a_sel = acc_q[cmd_i.sel];
  assign g_sel = grav_q[cmd_i.sel];
  assign r_sel = res_q[cmd_i.sel];
  assign s_sel = sm_q[cmd_i.sel[0]];

  // gravity low-pass
  assign gdiff = $signed({{2{a_sel[15]}}, a_sel, 8'h00}) - 26'(g_sel);
  assign gstep = 29'((prod_q + 45'sd32768) >>> 16);
  assign gsum  = 30'(g_sel) + 30'(gstep);
  always_comb begin
    if (gsum > 30'sd8388607) gnew = 24'sd8388607;
    else if (gsum < -30'sd8388608) gnew = -24'sd8388608;
    else gnew = gsum[23:0];
  end
  assign ground = 17'((25'(g_sel) + 25'sd128) >>> 8);

  // square root step
  assign sq_t = sq_r_q + {1'b0, sq_bit_q};

  // energy, envelope, direction
  assign e       = (sq_r_q > 36'd65535) ? 16'hFFFF : sq_r_q[15:0];
  assign ediff   = $signed({2'b00, e}) - $signed({2'b00, env_q});
  assign env_sum = $signed({2'b00, env_q}) + ((ediff + 18'sd2) >>> 2);
  always_comb begin
    if (env_sum < 18'sd0) env_new = '0;
    else if (env_sum > 18'sd65535) env_new = 16'hFFFF;
    else env_new = env_sum[15:0];
  end
  assign arx  = res_q[0][17] ? 18'(-res_q[0]) : 18'(res_q[0]);
  assign ary  = res_q[1][17] ? 18'(-res_q[1]) : 18'(res_q[1]);
  assign dsel = (arx >= ary) ? res_q[0] : res_q[1];
  always_comb begin
    if (dsel > 18'sd32767) dir_new = 16'sd32767;
    else if (dsel < -18'sd32768) dir_new = -16'sd32768;
    else dir_new = dsel[15:0];
  end

  // cordic
  assign g_ang = cmd_i.sel[0] ? grav_q[1] : grav_q[0];
  assign x0    = 27'(grav_q[2]);
  assign y0    = -27'(g_ang);
  assign ci    = cmd_i.it[3:0];
  assign xs    = cx_q >>> ci;
  assign ys    = cy_q >>> ci;

  // tilt target
  assign dead_deg = cmd_i.sel[0] ? ddead_q : sdead_q;
  assign full_deg = cmd_i.sel[0] ? dfull_q : sfull_q;
  assign mag      = cz_q[26] ? 27'(-cz_q) : 27'(cz_q);
  assign dead     = {dead_deg, 16'h0000};
  assign fdiff    = {1'b0, full_deg} - {2'b00, dead_deg};
  assign rem_sh   = {rem_q, num_q[26]};
  always_comb begin
    if (zero_q) tmag = '0;
    else if (full_q || num_q > 27'd16384) tmag = 15'd16384;
    else tmag = num_q[14:0];
  end

  // smoothing
  assign sdiff = 17'(tgt_q) - 17'(s_sel);
  assign sstep = 17'((prod_q + 45'sd32768) >>> 16);
  assign ssum  = 18'(s_sel) + 18'(sstep);
  always_comb begin
    if (ssum > 18'sd16384) snew = 16'sd16384;
    else if (ssum < -18'sd16384) snew = -16'sd16384;
    else snew = ssum[15:0];
  end

  // cutoff curve
  assign ej    = {1'b0, p_q[15:12]};
  assign ex_lo = exp2_val(ej);
  assign ex_hi = exp2_val(ej + 5'd1);
  assign ex_d  = ex_hi - ex_lo;
  assign n6    = 6'(p_q >>> 16);
  always_comb begin
    if (n6 > 6'sd0) nc = '0;
    else if (n6 < -6'sd20) nc = -6'sd20;
    else nc = n6;
  end
  assign sh     = 6'd16 - 6'(nc);
  assign vround = prod_q[37:0] + (38'd1 << (sh - 6'd1));
  assign vout   = vround >> sh;
  assign cut_new = (vout > 38'd16383) ? 14'h3FFF : vout[13:0];
  assign half    = (17'(sm_q[1]) + 17'sd1) >>> 1;

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_GMUL: begin mul_a = gdiff; mul_b = 19'(GRAV_K); end
      OP_SQM:  begin mul_a = 26'(r_sel); mul_b = 19'(r_sel); end
      OP_SMUL: begin mul_a = 26'(sdiff); mul_b = 19'(SMOOTH_K); end
      OP_KMUL: begin
        mul_a = 26'(sm_q[0]);
        mul_b = sm_q[0][15] ? 19'(K_DARK) : 19'(K_BRIGHT);
      end
      OP_KMUL2: begin mul_a = 26'(ex_d); mul_b = $signed({7'd0, p_q[11:0]}); end
      OP_KMUL3: begin mul_a = 26'(m_q); mul_b = 19'(CUT_BASE); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (cmd_i.op)
      OP_LOAD: begin
        acc_q[0] <= accel_x_i;
        acc_q[1] <= accel_y_i;
        acc_q[2] <= accel_z_i;
        time_q   <= time_ms_i;
        sleep_q  <= sleeping_i;
      end
      OP_RES: res_q[cmd_i.sel] <= 18'(a_sel) - 18'(ground);
      OP_SQA: sum_q <= ((cmd_i.sel == 2'd0) ? 35'd0 : sum_q) + prod_q[34:0];
      OP_SQI: begin
        sq_n_q   <= sum_q;
        sq_r_q   <= '0;
        sq_bit_q <= 35'(1) << 34;
      end
      OP_SQS: begin
        if ({1'b0, sq_n_q} >= sq_t) begin
          sq_n_q <= sq_n_q - sq_t[34:0];
          sq_r_q <= (sq_r_q >> 1) + {1'b0, sq_bit_q};
        end else begin
          sq_r_q <= sq_r_q >> 1;
        end
        sq_bit_q <= sq_bit_q >> 2;
      end
      OP_ENV: begin
        energy_q <= e;
        dir_q    <= dir_new;
      end
      OP_CINI: begin
        if (x0 < 27'sd0) begin
          cz_q <= (y0 >= 27'sd0) ? 27'(HALF_TURN_DEG) : -27'(HALF_TURN_DEG);
          cx_q <= -x0;
          cy_q <= -y0;
        end else begin
          cz_q <= '0;
          cx_q <= x0;
          cy_q <= y0;
        end
      end
      OP_CSTP: begin
        if (cy_q > 27'sd0) begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + atan_deg(ci);
        end else begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - atan_deg(ci);
        end
      end
      OP_TINI: begin
        zero_q <= (mag <= {4'd0, dead});
        full_q <= (full_deg <= {1'b0, dead_deg});
        d4_q   <= {fdiff[7:0], 2'b00};
        num_q  <= mag - {4'd0, dead};
        rem_q  <= '0;
      end
      OP_DSTP: begin
        if (rem_sh >= {1'b0, d4_q}) begin
          rem_q <= 10'(rem_sh - {1'b0, d4_q});
          num_q <= {num_q[25:0], 1'b1};
        end else begin
          rem_q <= rem_sh[9:0];
          num_q <= {num_q[25:0], 1'b0};
        end
      end
      OP_TFIN: tgt_q <= cz_q[26] ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
      OP_KIDX: p_q <= 20'((prod_q + 45'sd2048) >>> 12);
      OP_KMM:  m_q <= ex_lo + 18'(prod_q >>> 12);
      OP_KFIN: begin
        cut_q   <= cut_new;
        space_q <= 15'(17'sd8192 + half);
      end
      OP_COMMIT: begin
        o_fire_q   <= fire_q;
        o_energy_q <= energy_q;
        o_dir_q    <= dir_q;
        o_upd_q    <= tilt_en_q;
        o_side_q   <= sm_q[0];
        o_depth_q  <= sm_q[1];
        o_cut_q    <= cut_q;
        o_space_q  <= space_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q        <= SWING_ON_RST;
      off_q       <= SWING_OFF_RST;
      cool_q      <= COOLDOWN_RST;
      sdead_q     <= SIDE_DEAD_RST;
      sfull_q     <= SIDE_FULL_RST;
      ddead_q     <= DEPTH_DEAD_RST;
      dfull_q     <= DEPTH_FULL_RST;
      grav_q[0]   <= '0;
      grav_q[1]   <= '0;
      grav_q[2]   <= 24'sd1048576;
      env_q       <= '0;
      armed_q     <= 1'b1;
      last_q      <= '0;
      sm_q[0]     <= '0;
      sm_q[1]     <= '0;
      out_valid_q <= 1'b0;
      tilt_en_q   <= 1'b0;
      fire_q      <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (reg_e'(cfg_index_i))
          REG_SWING_ON:   on_q    <= cfg_data_i;
          REG_SWING_OFF:  off_q   <= cfg_data_i;
          REG_COOLDOWN:   cool_q  <= cfg_data_i;
          REG_SIDE_DEAD:  sdead_q <= cfg_data_i[6:0];
          REG_SIDE_FULL:  sfull_q <= cfg_data_i[7:0];
          REG_DEPTH_DEAD: ddead_q <= cfg_data_i[6:0];
          REG_DEPTH_FULL: dfull_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (cmd_i.op)
        OP_GUPD: grav_q[cmd_i.sel] <= gnew;
        OP_ENV: begin
          env_q     <= env_new;
          tilt_en_q <= !sleep_q && (env_new < 16'(ENV_QUARTER_G));
          fire_q    <= 1'b0;
          if (!sleep_q) begin
            if (armed_q && e > on_q && (time_q - last_q) > {16'd0, cool_q}) begin
              armed_q <= 1'b0;
              last_q  <= time_q;
              fire_q  <= 1'b1;
            end else if (e < off_q) begin
              armed_q <= 1'b1;
            end
          end
        end
        OP_SUPD:   sm_q[cmd_i.sel[0]] <= snew;
        OP_COMMIT: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  assign sts_o.tilt_en  = tilt_en_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign swing_fire_o      = o_fire_q;
  assign swing_energy_o    = o_energy_q;
  assign swing_direction_o = o_dir_q;
  assign tilts_updated_o   = o_upd_q;
  assign side_tilt_o       = o_side_q;
  assign depth_tilt_o      = o_depth_q;
  assign cutoff_hz_o       = o_cut_q;
  assign space_level_o     = o_space_q;

endmodule

// ===== hdl/accel_swing_and_tilt_gesture.sv =====
// ----------------------------------------------------------------------------
// accel_swing_and_tilt_gesture
// Swing detection and gravity tilt controls from one accelerometer sample
// A new sample is taken only in idle, after the previous result is committed;
// tilt steps run only when the tilts update. One shared multiplier, an 18-step
// square root, and per angle a 16-step CORDIC and a 27-step divider do the work.
// Reset: registers at defaults, gravity at 1 g on z, filters cleared, swing armed.
// ----------------------------------------------------------------------------
module accel_swing_and_tilt_gesture import ast_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  ast_in_if.sink    in_i,
  ast_out_if.source out_o,
  ast_cfg_if.sink   cfg_i
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  ast_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ast_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .accel_x_i         (in_i.accel_x),
    .accel_y_i         (in_i.accel_y),
    .accel_z_i         (in_i.accel_z),
    .time_ms_i         (in_i.time_ms),
    .sleeping_i        (in_i.sleeping),
    .cfg_valid_i       (cfg_i.valid),
    .cfg_index_i       (cfg_i.index),
    .cfg_data_i        (cfg_i.data),
    .out_ready_i       (out_o.ready),
    .out_valid_o       (out_o.valid),
    .swing_fire_o      (out_o.swing_fire),
    .swing_energy_o    (out_o.swing_energy),
    .swing_direction_o (out_o.swing_direction),
    .tilts_updated_o   (out_o.tilts_updated),
    .side_tilt_o       (out_o.side_tilt),
    .depth_tilt_o      (out_o.depth_tilt),
    .cutoff_hz_o       (out_o.cutoff_hz),
    .space_level_o     (out_o.space_level)
  );

endmodule
